@@ rtl/bdq_pkg.sv @@
// Shared types and constants for the bounded deque with positional insert.
package bdq_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned FOUND_W = 6;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_SEARCH     = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_POS   = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_POP,
    S_SEARCH
  } state_e;

endpackage

@@ rtl/bounded_deque_with_positional_insert_top.sv @@
// Bounded deque of signed 32-bit values with positional insert and search.
//
// One request is taken when start_i is high and busy_o is low; each request
// gives exactly one result, shown for a single cycle with done_o high, and
// the receiver cannot hold it off. Entries live in a single-port-read,
// single-port-write memory used as a ring buffer, so the cost of a request
// is set by how many entries it must read or move, one per cycle. Push
// front, push back, insert at position 0 or at the current count, and every
// refused request finish straight from idle; a pop reads one entry, then
// gives it; an insert at position p moves entries p onward one slot back,
// one per cycle, then writes the value; a search reads entries from the
// front, one per cycle, to the first match or the last. A new request may
// be accepted in the same cycle that done_o is high. The memory needs no
// clearing after reset: only entries below the count are ever used.
module bounded_deque_with_positional_insert_top
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [REQ_W-1:0]          req_type_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [POS_W-1:0]          position_i,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic signed [VALUE_W-1:0] removed_value_o,
  output logic [FOUND_W-1:0]        found_index_o,
  output logic [COUNT_W-1:0]        entry_count_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // ring pointer helpers
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) r = '0;
    else                     r = p + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == '0) r = AW'(DEPTH - 1);
    else         r = p - AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]       left_q, left_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [VALUE_W-1:0]  removed_q, removed_d;
  logic [AW-1:0]       found_q, found_d;

  logic [VALUE_W-1:0]  entry_mem [DEPTH];
  logic [VALUE_W-1:0]  rd_data_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  logic [VALUE_W-1:0]  mem_wdata;

  logic                accept;
  logic [AW-1:0]       cnt_lo;
  logic [AW-1:0]       cnt_m1;
  logic [CW-1:0]       ins_pos;
  logic                bad_pos;

  assign accept = start_i && (state_q == S_IDLE);
  assign cnt_lo = AW'(cnt_q);
  assign cnt_m1 = AW'(cnt_q - CW'(1));

  always_comb begin
    bad_pos = 1'b0;
    ins_pos = '0;
    case (req_e'(req_type_i))
      REQ_PUSH_FRONT: ins_pos = '0;
      REQ_PUSH_BACK:  ins_pos = cnt_q;
      default: begin
        ins_pos = CW'(position_i);
        bad_pos = CMPW'(position_i) > CMPW'(cnt_q);
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    left_d    = left_q;
    idx_d     = idx_q;
    val_d     = val_q;
    done_d    = 1'b0;
    status_d  = status_q;
    removed_d = removed_q;
    found_d   = found_q;
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_q;
    mem_wdata = rd_data_q;
    mem_raddr = rd_ptr_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d     = value_i;
          removed_d = '0;
          found_d   = '0;
          status_d  = STAT_OK;
          done_d    = 1'b1;
          case (req_e'(req_type_i))
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
              if (bad_pos) begin
                status_d = STAT_BAD_POS;
              end else if (cnt_q >= CW'(DEPTH)) begin
                status_d = STAT_FULL;
              end else if (ins_pos == '0) begin
                // grow at the front: move the head back one slot
                head_d    = ptr_dec(head_q);
                mem_we    = 1'b1;
                mem_waddr = ptr_dec(head_q);
                mem_wdata = value_i;
                cnt_d     = cnt_q + CW'(1);
              end else if (ins_pos == cnt_q) begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_q, cnt_lo);
                mem_wdata = value_i;
                cnt_d     = cnt_q + CW'(1);
              end else begin
                // open a gap: move entries from the back down to the position
                done_d    = 1'b0;
                mem_raddr = phys(head_q, cnt_m1);
                rd_ptr_d  = ptr_dec(phys(head_q, cnt_m1));
                wr_ptr_d  = phys(head_q, cnt_lo);
                left_d    = cnt_q - ins_pos;
                state_d   = S_SHIFT;
              end
            end
            REQ_POP_FRONT: begin
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                done_d    = 1'b0;
                mem_raddr = head_q;
                head_d    = ptr_inc(head_q);
                cnt_d     = cnt_q - CW'(1);
                state_d   = S_POP;
              end
            end
            REQ_POP_BACK: begin
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                done_d    = 1'b0;
                mem_raddr = phys(head_q, cnt_m1);
                cnt_d     = cnt_q - CW'(1);
                state_d   = S_POP;
              end
            end
            REQ_SEARCH: begin
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                done_d    = 1'b0;
                mem_raddr = head_q;
                rd_ptr_d  = ptr_inc(head_q);
                idx_d     = '0;
                state_d   = S_SEARCH;
              end
            end
            default: status_d = STAT_BAD_POS;
          endcase
        end
      end

      S_SHIFT: begin
        // write the entry read last cycle one slot back, read the next one
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q;
        mem_wdata = rd_data_q;
        mem_raddr = rd_ptr_q;
        rd_ptr_d  = ptr_dec(rd_ptr_q);
        wr_ptr_d  = ptr_dec(wr_ptr_q);
        left_d    = left_q - CW'(1);
        if (left_q == CW'(1)) state_d = S_PLACE;
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q;
        mem_wdata = val_q;
        cnt_d     = cnt_q + CW'(1);
        done_d    = 1'b1;
        status_d  = STAT_OK;
        state_d   = S_IDLE;
      end

      S_POP: begin
        removed_d = rd_data_q;
        status_d  = STAT_OK;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_SEARCH: begin
        if (rd_data_q == val_q) begin
          found_d  = idx_q;
          status_d = STAT_OK;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (CW'(idx_q) + CW'(1) == cnt_q) begin
          status_d = STAT_NOT_FOUND;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          mem_raddr = rd_ptr_q;
          rd_ptr_d  = ptr_inc(rd_ptr_q);
          idx_d     = idx_q + AW'(1);
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      left_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    wr_ptr_q  <= wr_ptr_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    found_q   <= found_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
    rd_data_q <= entry_mem[mem_raddr];
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign found_index_o   = FOUND_W'(found_q);
  assign entry_count_o   = COUNT_W'(cnt_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("entry count moved by more than one");

  a_no_stray_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !start_i) |=> !done_o)
    else $error("result without a request");

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == STAT_OK && found_q != '0) |-> (CW'(found_q) < cnt_q))
    else $error("found index beyond count");

  a_shift_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (left_q != '0) && (cnt_q < CW'(DEPTH)))
    else $error("shift without room or work");

endmodule
